@@ rtl/msbt_pkg.sv @@
// ----------------------------------------------------------------------------
// msbt_pkg: shared types and constants for the multi-slot blink/task timer
// Slot record, status codes, event record and walk states.
// ----------------------------------------------------------------------------
`default_nettype none

package msbt_pkg;

    // Table size and event limit per tick
    localparam int SLOTS      = 8;
    localparam int MAX_EVENTS = 8;

    // Field widths
    localparam int OPCODE_W   = 2;
    localparam int SLOT_W     = 3;
    localparam int TIME_W     = 16;
    localparam int REPEAT_W   = 15;
    localparam int RUNS_W     = 16;

    // Counter widths
    localparam int STEP_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int EVT_CNT_W  = $clog2(MAX_EVENTS + 1);

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_ACK   = 2'd2;

    typedef enum logic [2:0] {
        SS_IDLE    = 3'd0,
        SS_READY   = 3'd1,
        SS_PENDING = 3'd2,
        SS_RUNNING = 3'd3,
        SS_STOPPED = 3'd4
    } t_slot_status;

    typedef struct packed {
        t_slot_status        status;
        logic                flashing;
        logic [TIME_W-1:0]   on_ticks;
        logic [TIME_W-1:0]   off_ticks;
        logic [TIME_W-1:0]   ticks_left;
        logic [RUNS_W-1:0]   runs_left;
        logic                phase;
    } t_slot;

    // Event flags from one slot update
    typedef struct packed {
        logic valid;
        logic run_now;
        logic stopped;
    } t_upd_flags;

    // Event record without the last marker
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              run_now;
        logic              phase_on;
        logic              stopped;
    } t_event;

    typedef enum logic [1:0] {
        WS_IDLE  = 2'd0,
        WS_WALK  = 2'd1,
        WS_FLUSH = 2'd2
    } t_walk_state;

endpackage

`default_nettype wire

@@ rtl/msbt_in_if.sv @@
// ----------------------------------------------------------------------------
// msbt_in_if: command channel of the timer
// Valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
`default_nettype none

interface msbt_in_if;
    logic                                valid;
    logic                                ready;
    logic [msbt_pkg::OPCODE_W-1:0]       opcode;
    logic [msbt_pkg::SLOT_W-1:0]         slot;
    logic                                mode;
    logic [msbt_pkg::TIME_W-1:0]         on_time;
    logic [msbt_pkg::TIME_W-1:0]         off_time;
    logic [msbt_pkg::REPEAT_W-1:0]       repeat_count;

    modport source (
        output valid, opcode, slot, mode, on_time, off_time, repeat_count,
        input  ready
    );
    modport sink (
        input  valid, opcode, slot, mode, on_time, off_time, repeat_count,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/msbt_out_if.sv @@
// ----------------------------------------------------------------------------
// msbt_out_if: event channel of the timer
// Valid/ready handshake carrying one event item.
// ----------------------------------------------------------------------------
`default_nettype none

interface msbt_out_if;
    logic                          valid;
    logic                          ready;
    logic [msbt_pkg::SLOT_W-1:0]   event_slot;
    logic                          run_now;
    logic                          phase_on;
    logic                          stopped;
    logic                          last;

    modport source (
        output valid, event_slot, run_now, phase_on, stopped, last,
        input  ready
    );
    modport sink (
        input  valid, event_slot, run_now, phase_on, stopped, last,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/multi_slot_blink_task_timer.sv @@
// ----------------------------------------------------------------------------
// multi_slot_blink_task_timer: table of periodic and flashing timer slots
// Start and acknowledge write one slot; a tick rotates the slot chain once.
// ----------------------------------------------------------------------------
// A start item writes the addressed slot and an acknowledge item runs it if it is
// pending; a tick item is accepted, walks every slot through the update stage and
// releases the final event, and waits while an event waits on a stalled output.
// Events leave in slot order; each waits in a hold stage until the next event
// of its tick or the end of the walk, so the final one can carry last.
// Synchronous reset puts every slot idle with phase off and empties the output.
`default_nettype none

module multi_slot_blink_task_timer (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    msbt_in_if.sink      i_in,
    msbt_out_if.source   o_out
);

    localparam int N = msbt_pkg::SLOTS;

    msbt_pkg::t_slot       cell_rec  [N];
    msbt_pkg::t_slot       cell_load_rec [N];
    logic [N-1:0]          cell_load;
    msbt_pkg::t_slot       start_rec;
    msbt_pkg::t_slot       upd_rec;
    msbt_pkg::t_upd_flags  upd_flags;
    msbt_pkg::t_event      new_evt;

    msbt_pkg::t_walk_state                r_state,     n_state;
    logic [msbt_pkg::STEP_W-1:0]          r_step,      n_step;
    logic [msbt_pkg::EVT_CNT_W-1:0]       r_evt_cnt,   n_evt_cnt;
    logic                                 r_hold_valid, n_hold_valid;
    msbt_pkg::t_event                     r_hold,      n_hold;
    logic                                 r_out_valid, n_out_valid;
    msbt_pkg::t_event                     r_out,       n_out;
    logic                                 r_out_last,  n_out_last;

    logic in_acc;
    logic shift;
    logic emit;
    logic out_free;

    assign i_in.ready = (r_state == msbt_pkg::WS_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;

    // Build the record a start command writes
    always_comb begin
        start_rec            = '0;
        start_rec.status     = msbt_pkg::SS_READY;
        start_rec.flashing   = i_in.mode;
        start_rec.on_ticks   = i_in.on_time;
        start_rec.off_ticks  = i_in.off_time;
        start_rec.runs_left  = msbt_pkg::RUNS_W'(i_in.repeat_count);
    end

    // Slot chain: each cell takes its upper neighbor, the top takes the update
    for (genvar i = 0; i < N; i++) begin : g_cell
        logic sel;
        assign sel = (32'(i_in.slot) == i);

        always_comb begin
            cell_load_rec[i] = start_rec;
            cell_load[i]     = 1'b0;
            if (in_acc && sel) begin
                if (i_in.opcode == msbt_pkg::OP_START) begin
                    cell_load[i] = 1'b1;
                end else if (i_in.opcode == msbt_pkg::OP_ACK &&
                             cell_rec[i].status == msbt_pkg::SS_PENDING) begin
                    cell_load_rec[i]        = cell_rec[i];
                    cell_load_rec[i].status = msbt_pkg::SS_RUNNING;
                    cell_load[i]            = 1'b1;
                end
            end
        end

        if (i == N - 1) begin : g_top
            msbt_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_load      (cell_load[i]),
                .i_load_rec  (cell_load_rec[i]),
                .i_shift     (shift),
                .i_shift_rec (upd_rec),
                .o_rec       (cell_rec[i])
            );
        end else begin : g_mid
            msbt_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_load      (cell_load[i]),
                .i_load_rec  (cell_load_rec[i]),
                .i_shift     (shift),
                .i_shift_rec (cell_rec[i+1]),
                .o_rec       (cell_rec[i])
            );
        end
    end

    // Update the slot at the head of the chain
    msbt_update u_update (
        .i_rec   (cell_rec[0]),
        .o_rec   (upd_rec),
        .o_flags (upd_flags)
    );

    always_comb begin
        new_evt.slot     = msbt_pkg::SLOT_W'(r_step);
        new_evt.run_now  = upd_flags.run_now;
        new_evt.phase_on = upd_rec.phase;
        new_evt.stopped  = upd_flags.stopped;
    end

    assign emit = upd_flags.valid &&
                  (r_evt_cnt < msbt_pkg::EVT_CNT_W'(msbt_pkg::MAX_EVENTS));

    // Walk control, event hold stage and output register
    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_evt_cnt    = r_evt_cnt;
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_out_last   = r_out_last;
        shift        = 1'b0;

        // drop the output item once taken
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            msbt_pkg::WS_IDLE: begin
                if (in_acc && i_in.opcode == msbt_pkg::OP_TICK) begin
                    n_state   = msbt_pkg::WS_WALK;
                    n_step    = '0;
                    n_evt_cnt = '0;
                end
            end
            msbt_pkg::WS_WALK: begin
                // hold the chain while a new event has nowhere to go
                if (!(emit && r_hold_valid && !out_free)) begin
                    shift = 1'b1;
                    if (emit) begin
                        if (r_hold_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_hold;
                            n_out_last  = 1'b0;
                        end
                        n_hold_valid = 1'b1;
                        n_hold       = new_evt;
                        n_evt_cnt    = r_evt_cnt + msbt_pkg::EVT_CNT_W'(1);
                    end
                    if (r_step == msbt_pkg::STEP_W'(N - 1)) begin
                        n_state = msbt_pkg::WS_FLUSH;
                    end else begin
                        n_step = r_step + msbt_pkg::STEP_W'(1);
                    end
                end
            end
            msbt_pkg::WS_FLUSH: begin
                // release the final event of this tick with last set
                if (!r_hold_valid) begin
                    n_state = msbt_pkg::WS_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = r_hold;
                    n_out_last   = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = msbt_pkg::WS_IDLE;
                end
            end
            default: begin
                n_state = msbt_pkg::WS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= msbt_pkg::WS_IDLE;
            r_step       <= '0;
            r_evt_cnt    <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_evt_cnt    <= n_evt_cnt;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_hold     <= n_hold;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.event_slot = r_out.slot;
    assign o_out.run_now    = r_out.run_now;
    assign o_out.phase_on   = r_out.phase_on;
    assign o_out.stopped    = r_out.stopped;
    assign o_out.last       = r_out_last;

endmodule

`default_nettype wire

@@ rtl/msbt_cell.sv @@
// ----------------------------------------------------------------------------
// msbt_cell: one timer slot register of the slot chain
// Holds one slot record; loads it directly or takes the neighbor's record.
// ----------------------------------------------------------------------------
`default_nettype none

module msbt_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire msbt_pkg::t_slot  i_load_rec,
    input  wire logic             i_shift,
    input  wire msbt_pkg::t_slot  i_shift_rec,
    output msbt_pkg::t_slot       o_rec
);

    msbt_pkg::t_slot r_rec;

    // Clear status and phase on reset; times and counts stay until written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.status   <= msbt_pkg::SS_IDLE;
            r_rec.flashing <= 1'b0;
            r_rec.phase    <= 1'b0;
        end else if (i_load) begin
            r_rec <= i_load_rec;
        end else if (i_shift) begin
            r_rec <= i_shift_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

`default_nettype wire

@@ rtl/msbt_update.sv @@
// ----------------------------------------------------------------------------
// msbt_update: tick update of the slot at the head of the chain
// Loads ready slots, counts running slots down and flags due/stop events.
// ----------------------------------------------------------------------------
`default_nettype none

module msbt_update (
    input  wire msbt_pkg::t_slot i_rec,
    output msbt_pkg::t_slot      o_rec,
    output msbt_pkg::t_upd_flags o_flags
);

    logic [msbt_pkg::TIME_W-1:0] ticks_dec;
    logic [msbt_pkg::RUNS_W-1:0] runs_dec;

    assign ticks_dec = i_rec.ticks_left - msbt_pkg::TIME_W'(1);
    assign runs_dec  = i_rec.runs_left - msbt_pkg::RUNS_W'(1);

    always_comb begin
        o_rec   = i_rec;
        o_flags = '0;
        case (i_rec.status)
            // Ready: load the countdown, double the runs when flashing and raise a due event
            msbt_pkg::SS_READY: begin
                o_rec.ticks_left = i_rec.on_ticks;
                if (i_rec.flashing) begin
                    o_rec.runs_left = {i_rec.runs_left[msbt_pkg::RUNS_W-2:0], 1'b0};
                    o_rec.phase     = 1'b1;
                end
                o_rec.status    = msbt_pkg::SS_PENDING;
                o_flags.valid   = 1'b1;
                o_flags.run_now = 1'b1;
            end
            // Running: count down; on expiry reload and consume one repeat unless runs are zero
            msbt_pkg::SS_RUNNING: begin
                o_rec.ticks_left = ticks_dec;
                if (ticks_dec == '0) begin
                    if (!i_rec.flashing) begin
                        o_rec.ticks_left = i_rec.on_ticks;
                    end else if (i_rec.phase) begin
                        o_rec.ticks_left = i_rec.off_ticks;
                        o_rec.phase      = 1'b0;
                    end else begin
                        o_rec.ticks_left = i_rec.on_ticks;
                        o_rec.phase      = 1'b1;
                    end
                    o_flags.valid = 1'b1;
                    if (i_rec.runs_left == '0) begin
                        o_rec.status    = msbt_pkg::SS_PENDING;
                        o_flags.run_now = 1'b1;
                    end else begin
                        o_rec.runs_left = runs_dec;
                        if (runs_dec == '0) begin
                            o_rec.status    = msbt_pkg::SS_STOPPED;
                            o_flags.stopped = 1'b1;
                        end else begin
                            o_rec.status    = msbt_pkg::SS_PENDING;
                            o_flags.run_now = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
